// ----- rtl/rmq_pkg.sv -----
// rmq_pkg: shared types and constants for the rotation matrix to quaternion unit
// depends on nothing; used by every other file under rtl
package rmq_pkg;

  localparam int unsigned ElemW  = 16;
  localparam int unsigned NumW   = 17;
  localparam int unsigned RadW   = 32;
  localparam int unsigned RootW  = 16;
  localparam int unsigned DivW   = 17;
  localparam int unsigned RemW   = 32;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned Lanes  = 3;

  typedef enum logic [1:0] {
    SEL_TRACE = 2'd0,
    SEL_X     = 2'd1,
    SEL_Y     = 2'd2,
    SEL_Z     = 2'd3
  } sel_e;

  // numerators and branch ride along the root chain
  typedef struct packed {
    sel_e                   sel;
    logic signed [NumW-1:0] d0;
    logic signed [NumW-1:0] d1;
    logic signed [NumW-1:0] d2;
  } ctx_t;

  typedef struct packed {
    logic [RadW-1:0] n;
    logic [RadW-1:0] res;
    ctx_t            ctx;
  } sq_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DivW-1:0] quo;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    logic [DivW-1:0]  s;
    logic             zero;
    sel_e             sel;
    logic [14:0]      own;
    lane_t [Lanes-1:0] ln;
  } dv_t;

endpackage

// ----- rtl/rmq_sqrt_cell.sv -----
// rmq_sqrt_cell: one digit step of the integer square root, registered
// depends on rmq_pkg
module rmq_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rmq_pkg::sq_t  data_i,
  output logic          valid_o,
  output rmq_pkg::sq_t  data_o
);

  localparam logic [rmq_pkg::RadW:0] Bit = (rmq_pkg::RadW+1)'(1) << (2 * K);

  logic          valid_q;
  rmq_pkg::sq_t  data_q, data_d;
  logic [rmq_pkg::RadW:0] trial;

  always_comb begin
    data_d = data_i;
    trial  = {1'b0, data_i.res} + Bit;
    if ({1'b0, data_i.n} >= trial) begin
      data_d.n   = data_i.n - trial[rmq_pkg::RadW-1:0];
      data_d.res = (data_i.res >> 1) + Bit[rmq_pkg::RadW-1:0];
    end else begin
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rmq_div_cell.sv -----
// rmq_div_cell: one quotient bit of three parallel restoring divides, registered
// depends on rmq_pkg
module rmq_div_cell #(
  parameter int unsigned B = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rmq_pkg::dv_t  data_i,
  output logic          valid_o,
  output rmq_pkg::dv_t  data_o
);

  localparam int unsigned TW = rmq_pkg::RemW + 2;

  logic          valid_q;
  rmq_pkg::dv_t  data_q, data_d;
  logic [TW-1:0] shifted;
  logic [TW-1:0] rem_ext;

  always_comb begin
    data_d  = data_i;
    shifted = TW'(data_i.s) << B;
    rem_ext = '0;
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      rem_ext = TW'(data_i.ln[l].rem);
      if (rem_ext >= shifted) begin
        data_d.ln[l].rem    = data_i.ln[l].rem - shifted[rmq_pkg::RemW-1:0];
        data_d.ln[l].quo[B] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// rotation_matrix_to_quaternion_unit: top level, branch select, root and divide chains
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell
//
// Converts a 3x3 rotation block in signed Q1.15 to a quaternion (x, y, z, w) in
// signed Q1.15 by Shepperd's method, and reports the branch taken on m_axis_tuser
// (0 trace positive, 1 x largest, 2 y largest, 3 z largest). The unit takes a new
// word every cycle unless m_axis stalls and hands out one result word per input
// word, in order. Its stages are the register for branch selection and the branch
// sum, sixteen cells of the bit-pair square root chain, a register that forms
// s = 2*root and the dividends, seventeen cells of the restoring divide chain (three
// lanes side by side) and the output register with sign and saturation. The whole
// chain moves as one when the output register is empty or being drained, so a stall
// on m_axis holds every stage in place and s_axis_tready follows directly.
module rotation_matrix_to_quaternion_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, lowest first)
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // qx, qy, qz, qw (16 bits each, lowest first)
  output logic [63:0]  m_axis_tdata,
  // case_taken
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned SW = rmq_pkg::SqrtSteps;
  localparam int unsigned DW = rmq_pkg::DivW;

  // global advance: whole chain shifts when the output slot frees up
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- branch select and sum ----------------
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  assign r00 = s_axis_tdata[15:0];
  assign r01 = s_axis_tdata[31:16];
  assign r02 = s_axis_tdata[47:32];
  assign r10 = s_axis_tdata[63:48];
  assign r11 = s_axis_tdata[79:64];
  assign r12 = s_axis_tdata[95:80];
  assign r20 = s_axis_tdata[111:96];
  assign r21 = s_axis_tdata[127:112];
  assign r22 = s_axis_tdata[143:128];

  logic signed [18:0] e00, e11, e22, tr, sum;
  logic [16:0]        sum_c;
  rmq_pkg::sel_e      sel;
  rmq_pkg::sq_t       s0_d;

  always_comb begin
    e00 = 19'(r00);
    e11 = 19'(r11);
    e22 = 19'(r22);
    tr  = e00 + e11 + e22;
    if (tr > 19'sd0) begin
      sel = rmq_pkg::SEL_TRACE;
      sum = 19'sd32768 + tr;
    end else if (r00 > r11 && r00 > r22) begin
      sel = rmq_pkg::SEL_X;
      sum = 19'sd32768 + e00 - e11 - e22;
    end else if (r11 > r22) begin
      sel = rmq_pkg::SEL_Y;
      sum = 19'sd32768 + e11 - e00 - e22;
    end else begin
      sel = rmq_pkg::SEL_Z;
      sum = 19'sd32768 + e22 - e00 - e11;
    end
    // negative sums only come from non-rotation input
    sum_c = sum[18] ? 17'd0 : sum[16:0];

    s0_d.n       = {sum_c, 15'd0};
    s0_d.res     = '0;
    s0_d.ctx.sel = sel;
    case (sel)
      rmq_pkg::SEL_TRACE: begin
        s0_d.ctx.d0 = 17'(r21) - 17'(r12);
        s0_d.ctx.d1 = 17'(r02) - 17'(r20);
        s0_d.ctx.d2 = 17'(r10) - 17'(r01);
      end
      rmq_pkg::SEL_X: begin
        s0_d.ctx.d0 = 17'(r21) - 17'(r12);
        s0_d.ctx.d1 = 17'(r01) + 17'(r10);
        s0_d.ctx.d2 = 17'(r02) + 17'(r20);
      end
      rmq_pkg::SEL_Y: begin
        s0_d.ctx.d0 = 17'(r02) - 17'(r20);
        s0_d.ctx.d1 = 17'(r01) + 17'(r10);
        s0_d.ctx.d2 = 17'(r12) + 17'(r21);
      end
      default: begin
        s0_d.ctx.d0 = 17'(r10) - 17'(r01);
        s0_d.ctx.d1 = 17'(r02) + 17'(r20);
        s0_d.ctx.d2 = 17'(r12) + 17'(r21);
      end
    endcase
  end

  logic         s0_valid_q;
  rmq_pkg::sq_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
    end
  end

  // ---------------- square root chain ----------------
  // cell for bit pair k sits at position SW-1-k
  logic         sq_v [SW+1];
  rmq_pkg::sq_t sq_d [SW+1];
  assign sq_v[0] = s0_valid_q;
  assign sq_d[0] = s0_q;

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    rmq_sqrt_cell #(.K(SW - 1 - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[g]),
      .data_i  (sq_d[g]),
      .valid_o (sq_v[g+1]),
      .data_o  (sq_d[g+1])
    );
  end

  // ---------------- divide setup ----------------
  rmq_pkg::sq_t              sq_last;
  logic [rmq_pkg::RootW-1:0] root;
  logic signed [16:0]        dn [rmq_pkg::Lanes];
  logic [16:0]               mag;
  rmq_pkg::dv_t              dv0_d;

  assign sq_last = sq_d[SW];
  assign root    = sq_last.res[rmq_pkg::RootW-1:0];
  assign dn[0]   = sq_last.ctx.d0;
  assign dn[1]   = sq_last.ctx.d1;
  assign dn[2]   = sq_last.ctx.d2;

  always_comb begin
    dv0_d.s    = {root, 1'b0};
    dv0_d.zero = (root == '0);
    dv0_d.sel  = sq_last.ctx.sel;
    dv0_d.own  = root[15:1];
    mag        = '0;
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      mag               = dn[l][16] ? 17'(-dn[l]) : 17'(dn[l]);
      dv0_d.ln[l].rem   = {mag[16:0], 15'd0};
      dv0_d.ln[l].quo   = '0;
      dv0_d.ln[l].neg   = dn[l][16];
      // quotient would be 32768 or more, so the term saturates
      dv0_d.ln[l].ovf   = (mag >= {root, 1'b0});
    end
  end

  logic         dv0_valid_q;
  rmq_pkg::dv_t dv0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_valid_q <= 1'b0;
    end else if (adv) begin
      dv0_valid_q <= sq_v[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv0_q <= dv0_d;
    end
  end

  // ---------------- divide chain ----------------
  logic         dv_v [DW+1];
  rmq_pkg::dv_t dv_d [DW+1];
  assign dv_v[0] = dv0_valid_q;
  assign dv_d[0] = dv0_q;

  for (genvar g = 0; g < DW; g++) begin : g_div
    rmq_div_cell #(.B(DW - 1 - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[g]),
      .data_i  (dv_d[g]),
      .valid_o (dv_v[g+1]),
      .data_o  (dv_d[g+1])
    );
  end

  // ---------------- sign, saturate, place ----------------
  rmq_pkg::dv_t       dv_last;
  logic signed [15:0] term [rmq_pkg::Lanes];
  logic signed [15:0] own_s;
  logic [63:0]        out_d;

  assign dv_last = dv_d[DW];
  assign own_s   = {1'b0, dv_last.own};

  always_comb begin
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      if (dv_last.zero) begin
        term[l] = '0;
      end else if (!dv_last.ln[l].neg) begin
        if (dv_last.ln[l].ovf || dv_last.ln[l].quo > 17'd32767) begin
          term[l] = 16'sh7FFF;
        end else begin
          term[l] = dv_last.ln[l].quo[15:0];
        end
      end else begin
        if (dv_last.ln[l].ovf || dv_last.ln[l].quo > 17'd32768) begin
          term[l] = 16'sh8000;
        end else begin
          term[l] = 16'(-dv_last.ln[l].quo);
        end
      end
    end
    // fields: qx, qy, qz, qw
    case (dv_last.sel)
      rmq_pkg::SEL_TRACE: out_d = {own_s,   term[2], term[1], term[0]};
      rmq_pkg::SEL_X:     out_d = {term[0], term[2], term[1], own_s};
      rmq_pkg::SEL_Y:     out_d = {term[0], term[2], own_s,   term[1]};
      default:            out_d = {term[0], own_s,   term[2], term[1]};
    endcase
  end

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
      out_user_q <= dv_last.sel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/rmq_checker.sv -----
// rmq_checker: port-level assertions for the rotation matrix to quaternion unit
// depends on rmq_pkg; bound to rotation_matrix_to_quaternion_unit
module rmq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // a stalled result word stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // input side never blocks while the output slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // the branch's own component is a root, never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rmq_pkg::SEL_TRACE |-> !m_axis_tdata[63])
    else $error("negative w on trace branch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rmq_pkg::SEL_X |-> !m_axis_tdata[15])
    else $error("negative x on x branch");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
